### rtl/crma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crma_pkg;
  localparam int NumModules = 4;
  localparam int PixelsPerModule = 64;
  localparam int NumCells = 64;
  localparam int NumAmpSteps = 16;
  localparam int ModW = 2;
  localparam int PixW = 6;
  localparam int CellW = 6;
  localparam int AmpW = 4;
  localparam int AddrW = ModW + PixW + CellW + AmpW;
  localparam int Depth = 1 << AddrW;
  localparam int MeanW = 22;
  localparam int CountW = 16;
  localparam int NumW = MeanW + CountW + 1;
  localparam int QuoW = NumW;
  localparam int DivCntW = 6;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic mul;
    logic div_start;
    logic div_step;
    logic write;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
  } status_t;
endpackage
`default_nettype wire

### rtl/cell_running_mean_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// Running mean per module, pixel, cell and amplitude step, in Q13.8 with a
// 16-bit hit count. After reset the block clears both stores before it takes
// an item. Each item then goes through a read, a multiply, one restoring
// divider step per quotient bit of the 39-bit division by n+1, a write and
// the output; saturated or out-of-range items skip the division and the
// write. One item at a time.
module cell_running_mean_accumulator import crma_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [AmpW-1:0]         amp_step_index,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [13:0]      sample_value,
  input  wire logic [7:0]              sample_index,
  input  wire logic [ModW-1:0]         module_index,
  input  wire logic [PixW-1:0]         pixel_index,
  input  wire logic [11:0]             first_cell,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [MeanW-1:0]      new_mean,
  output logic [CountW-1:0]            hit_count,
  output logic [CellW-1:0]             cell_number,
  output logic                         saturated
);
  cmd_t cmd;
  status_t status;
  logic busy, in_range, sat_now, in_accept, out_accept;
  logic [AmpW-1:0] amp_step;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      amp_step <= '0;
    end else if (cfg_valid) begin
      amp_step <= amp_step_index;
    end
  end

  assign in_stall = busy;
  assign in_accept = in_valid && !busy;
  assign out_accept = out_valid && !out_stall;

  crma_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_accept(in_accept), .out_accept(out_accept),
    .in_range(in_range), .sat_now(sat_now), .status(status), .cmd(cmd),
    .busy(busy), .out_valid(out_valid)
  );

  crma_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .amp_step(amp_step),
    .sample_value(sample_value), .sample_index(sample_index),
    .module_index(module_index), .pixel_index(pixel_index),
    .first_cell(first_cell), .in_range(in_range), .sat_now(sat_now),
    .new_mean(new_mean), .hit_count(hit_count), .cell_number(cell_number),
    .saturated(saturated)
  );
endmodule
`default_nettype wire

### rtl/crma_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module crma_ram #(
  parameter int Width = 8,
  parameter int DepthP = 16
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DepthP)-1:0] waddr,
  input  wire logic [Width-1:0]          wdata,
  input  wire logic [$clog2(DepthP)-1:0] raddr,
  output logic [Width-1:0]               rdata
);
  logic [Width-1:0] mem [DepthP];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/crma_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module crma_ctrl import crma_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_accept,
  input  wire logic    out_accept,
  input  wire logic    in_range,
  input  wire logic    sat_now,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         out_valid
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (in_accept) state_next = ST_READ;
      ST_READ:  state_next = ST_MUL;
      ST_MUL: begin
        if (!in_range || sat_now) state_next = ST_OUT;
        else state_next = ST_DIV;
      end
      ST_DIV:   if (status.div_done) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (out_accept) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        cmd.capture = in_accept;
      end
      ST_READ:  cmd.mul = 1'b1;
      ST_MUL: begin
        cmd.div_start = 1'b1;
        cmd.finish = !in_range || sat_now;
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_WRITE: begin
        cmd.write = 1'b1;
        cmd.finish = 1'b1;
      end
      ST_OUT:   out_valid = 1'b1;
      default:  busy = 1'b1;
    endcase
  end
endmodule
`default_nettype wire

### rtl/crma_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module crma_datapath import crma_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic [AmpW-1:0]    amp_step,
  input  wire logic signed [13:0] sample_value,
  input  wire logic [7:0]         sample_index,
  input  wire logic [ModW-1:0]    module_index,
  input  wire logic [PixW-1:0]    pixel_index,
  input  wire logic [11:0]        first_cell,
  output logic                    in_range,
  output logic                    sat_now,
  output logic signed [MeanW-1:0] new_mean,
  output logic [CountW-1:0]       hit_count,
  output logic [CellW-1:0]        cell_number,
  output logic                    saturated
);
  logic [AddrW-1:0] addr, clr_addr, addr_in, raddr;
  logic [AddrW:0] clr_cnt;
  logic signed [13:0] samp;
  logic [CellW-1:0] cell_id;
  logic [12:0] cell_sum;
  logic [MeanW-1:0] mean_rd;
  logic [CountW-1:0] count_rd;
  logic [CountW-1:0] n;
  logic neg;
  logic [CountW:0] den;
  logic [NumW-1:0] quo;
  logic [CountW+1:0] rem, rem_sh, rem_sub;
  logic [DivCntW-1:0] div_cnt;
  logic signed [NumW-1:0] num;
  logic signed [MeanW-1:0] res_mean;
  logic we;
  logic [AddrW-1:0] waddr;
  logic [MeanW-1:0] wmean;
  logic [CountW-1:0] wcount;

  assign cell_sum = {1'b0, first_cell} + {5'd0, sample_index};
  assign status.clear_done = clr_cnt[AddrW];
  assign sat_now = (count_rd == CountMax);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step && !clr_cnt[AddrW]) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign clr_addr = clr_cnt[AddrW-1:0];

  assign addr_in = {module_index, pixel_index, cell_sum[CellW-1:0], amp_step};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp <= sample_value;
      cell_id <= cell_sum[CellW-1:0];
      addr <= addr_in;
      in_range <= (32'(module_index) < NumModules) && (32'(pixel_index) < PixelsPerModule)
                  && (32'(amp_step) < NumAmpSteps);
    end
  end

  assign raddr = cmd.capture ? addr_in : addr;
  assign we = cmd.clear_step || cmd.write;
  assign waddr = cmd.clear_step ? clr_addr : addr;
  assign wmean = cmd.clear_step ? '0 : res_mean;
  assign wcount = cmd.clear_step ? '0 : n + 1'b1;

  crma_ram #(.Width(MeanW), .DepthP(Depth)) u_mean (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wmean), .raddr(raddr), .rdata(mean_rd)
  );
  crma_ram #(.Width(CountW), .DepthP(Depth)) u_count (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wcount), .raddr(raddr), .rdata(count_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num <= NumW'($signed(mean_rd) * $signed({1'b0, count_rd}))
             + NumW'(samp) * NumW'(256);
    end
  end

  assign rem_sh = {rem[CountW:0], quo[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      n <= count_rd;
      neg <= num[NumW-1];
      quo <= (num[NumW-1] ? NumW'(-num) : NumW'(num)) + NumW'(({1'b0, count_rd} + 1'b1) >> 1);
      den <= {1'b0, count_rd} + 1'b1;
      rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[CountW+1]) begin
        rem <= rem_sub;
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NumW-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end
  assign status.div_done = (div_cnt == DivCntW'(QuoW - 1)) && cmd.div_step;

  always_comb begin
    res_mean = neg ? -MeanW'(quo) : MeanW'(quo);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cell_number <= cell_id;
      if (!in_range) begin
        new_mean <= '0;
        hit_count <= '0;
        saturated <= 1'b0;
      end else if (cmd.write) begin
        new_mean <= res_mean;
        hit_count <= n + 1'b1;
        saturated <= 1'b0;
      end else begin
        new_mean <= $signed(mean_rd);
        hit_count <= CountMax;
        saturated <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### dv/cell_running_mean_accumulator_tb.sv
`timescale 1ns / 1ps
module cell_running_mean_accumulator_tb;
  import crma_pkg::*;

  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic signed [13:0] value;
    logic [7:0]         sidx;
    logic [ModW-1:0]    mod;
    logic [PixW-1:0]    pix;
    logic [11:0]        fc;
  } sample_t;

  typedef struct packed {
    logic signed [MeanW-1:0] mean;
    logic [CountW-1:0]       count;
    logic [CellW-1:0]        cell_no;
    logic                    sat;
  } mean_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [AmpW-1:0] amp_step_index = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [13:0] sample_value = '0;
  logic [7:0] sample_index = '0;
  logic [ModW-1:0] module_index = '0;
  logic [PixW-1:0] pixel_index = '0;
  logic [11:0] first_cell = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [MeanW-1:0] new_mean;
  logic [CountW-1:0] hit_count;
  logic [CellW-1:0] cell_number;
  logic saturated;

  sample_t samples_q[$];
  mean_update_t expected_means[$];
  longint mean_mem[int];
  longint hits_mem[int];
  logic [AmpW-1:0] amp_reg = '0;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int hot_pix[4];
  int hot_cell[4];

  cell_running_mean_accumulator uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .amp_step_index(amp_step_index),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_value(sample_value), .sample_index(sample_index),
    .module_index(module_index), .pixel_index(pixel_index), .first_cell(first_cell),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_mean(new_mean), .hit_count(hit_count), .cell_number(cell_number),
    .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mean_update_t fold_sample(sample_t s);
    mean_update_t r;
    int addr;
    longint n, old_mean, num, mag, q;
    r.cell_no = CellW'((int'(s.fc) + int'(s.sidx)) % NumCells);
    addr = int'({s.mod, s.pix, r.cell_no, amp_reg});
    n = hits_mem.exists(addr) ? hits_mem[addr] : 0;
    old_mean = mean_mem.exists(addr) ? mean_mem[addr] : 0;
    if (n >= longint'(CountMax)) begin
      r.mean = MeanW'(old_mean);
      r.count = CountMax;
      r.sat = 1'b1;
    end else begin
      num = old_mean * n + longint'($signed(s.value)) * 256;
      mag = (num < 0) ? -num : num;
      q = (mag + (n + 1) / 2) / (n + 1);
      if (num < 0) q = -q;
      mean_mem[addr] = q;
      hits_mem[addr] = n + 1;
      r.mean = MeanW'(q);
      r.count = CountW'(n + 1);
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic sample_t make_sample();
    sample_t s;
    int c;
    s.sidx = 8'($urandom_range(0, 255));
    s.fc = 12'($urandom_range(0, 4095));
    s.mod = ModW'($urandom_range(0, 3));
    s.pix = PixW'($urandom_range(0, 63));
    if ($urandom_range(0, 9) < 7) begin
      s.pix = PixW'(hot_pix[$urandom_range(0, 3)]);
      s.mod = ModW'($urandom_range(0, 1));
      c = hot_cell[$urandom_range(0, 3)];
      s.fc = 12'(((c - int'(s.sidx)) & 63) + 64 * $urandom_range(0, 63));
    end
    case ($urandom_range(0, 9))
      0: s.value = 14'sh2000;
      1: s.value = 14'sh1fff;
      2, 3: s.value = 14'($urandom_range(0, 16383));
      default: s.value = 14'($urandom_range(0, 200) - 100 + 300);
    endcase
    return s;
  endfunction

  task automatic push_sample(int v, int si, int m, int p, int f);
    sample_t s;
    s.value = 14'(v);
    s.sidx = 8'(si);
    s.mod = ModW'(m);
    s.pix = PixW'(p);
    s.fc = 12'(f);
    samples_q = {samples_q, s};
  endtask

  task automatic write_amp(logic [AmpW-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    amp_step_index <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    amp_reg = v;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (samples_q.size() != 0 || in_valid || expected_means.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  // drive items
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        expected_means = {expected_means,
                          fold_sample({sample_value, sample_index, module_index,
                                       pixel_index, first_cell})};
      if (samples_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        {sample_value, sample_index, module_index, pixel_index, first_cell} <=
          samples_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // stall the result side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 500;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // check results
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        $error("unexpected item: mean %0d count %0d", new_mean, hit_count);
        errors++;
      end else begin
        mean_update_t e;
        e = expected_means.pop_front();
        if (new_mean !== e.mean) begin
          $error("new_mean expected %0d actual %0d", e.mean, new_mean);
          errors++;
        end
        if (hit_count !== e.count) begin
          $error("hit_count expected %0d actual %0d", e.count, hit_count);
          errors++;
        end
        if (cell_number !== e.cell_no) begin
          $error("cell_number expected %0d actual %0d", e.cell_no, cell_number);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      hot_pix[i] = $urandom_range(0, 63);
      hot_cell[i] = $urandom_range(0, 63);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_amp(4'd0);

    push_sample(-8192, 0, 0, 0, 0);
    push_sample(8191, 0, 0, 0, 0);
    push_sample(8191, 255, 3, 63, 4095);
    push_sample(-8192, 255, 3, 63, 4095);
    push_sample(0, 255, 3, 63, 4095);
    push_sample(1, 10, 1, 5, 54);
    push_sample(2, 10, 1, 5, 54);
    push_sample(-1, 10, 1, 5, 54);
    push_sample(-2, 10, 1, 5, 54);
    push_sample(3, 10, 1, 5, 54);
    push_sample(-1, 0, 2, 32, 63);
    push_sample(-1, 1, 2, 32, 63);
    push_sample(100, 128, 1, 31, 2048);
    push_sample(-100, 127, 2, 33, 2047);
    for (int i = 0; i < 6; i++) push_sample(8191 - i, 7, 3, 0, 57);
    drain();
    write_amp(4'd15);
    push_sample(8191, 255, 3, 63, 4095);
    push_sample(-8192, 0, 0, 0, 0);
    push_sample(5, 10, 1, 5, 54);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; write_amp(4'd0); end
        1: begin send_idle_pct = 71; recv_stall_pct = 0; write_amp(4'd15); end
        2: begin send_idle_pct = 0; recv_stall_pct = 71; write_amp(4'($urandom_range(1, 14))); end
        3: begin send_idle_pct = 38; recv_stall_pct = 38; write_amp(4'd7); end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; write_amp(4'd0); end
      endcase
      for (int i = 0; i < 146; i++) samples_q = {samples_q, make_sample()};
      if (ph == 4) hold_req = hold_req + 1;
    end

    do @(posedge clk);
    while (samples_q.size() != 0 || in_valid || expected_means.size() != 0);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
